### rtl/mlp_pkg.sv
// ----------------------------------------------------------------------------
// mlp_pkg: shared types, constants and helpers
// Q8.8 dense network inference package.
// ----------------------------------------------------------------------------
`default_nettype none
package mlp_pkg;

  localparam int MAX_LAYERS = 4;
  localparam int MAX_WIDTH  = 16;
  localparam int DATA_BITS  = 16;

  localparam int WIDX_BITS  = $clog2(MAX_WIDTH);
  localparam int LIDX_BITS  = $clog2(MAX_LAYERS);
  localparam int WMEM_DEPTH = (MAX_LAYERS - 1) * MAX_WIDTH * MAX_WIDTH;
  localparam int BMEM_DEPTH = (MAX_LAYERS - 1) * MAX_WIDTH;
  localparam int NMEM_DEPTH = MAX_LAYERS * MAX_WIDTH;
  localparam int AMEM_DEPTH = 2 * MAX_WIDTH;
  localparam int WADDR_BITS = $clog2(WMEM_DEPTH);
  localparam int BADDR_BITS = $clog2(BMEM_DEPTH);
  localparam int NADDR_BITS = $clog2(NMEM_DEPTH);
  localparam int AADDR_BITS = $clog2(AMEM_DEPTH);

  // operation codes
  typedef enum logic [2:0] {
    OP_WEIGHT = 3'd0, OP_BIAS = 3'd1, OP_MEAN = 3'd2, OP_INVDEV = 3'd3,
    OP_GAMMA = 3'd4, OP_BETA = 3'd5, OP_SAMPLE = 3'd6, OP_NONE = 3'd7
  } op_t;

  // configuration register indexes
  localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
  localparam logic [2:0] REG_WIDTH0      = 3'd1;
  localparam logic [2:0] REG_WIDTH1      = 3'd2;
  localparam logic [2:0] REG_WIDTH2      = 3'd3;
  localparam logic [2:0] REG_WIDTH3      = 3'd4;
  localparam logic [2:0] REG_ACT_CODES   = 3'd5;
  localparam logic [2:0] REG_NORM_EN     = 3'd6;

  // activation codes
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_RELU = 2'd1;
  localparam logic [1:0] ACT_SIG  = 2'd2;
  localparam logic [1:0] ACT_TANH = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_IN_RD, ST_IN_NORM1, ST_IN_NORM2, ST_IN_WR,
    ST_BIAS, ST_MAC, ST_MAC_LAST, ST_POST, ST_NORM1, ST_NORM2, ST_WR,
    ST_OUT_RD, ST_OUT_WAIT, ST_OUT
  } state_t;

  // sigmoid breakpoints, x = 0, 0.5, ... 8
  function automatic logic [8:0] sig_tab(input logic [4:0] i);
    case (i)
      5'd0: sig_tab = 9'd128;  5'd1: sig_tab = 9'd159;  5'd2: sig_tab = 9'd187;
      5'd3: sig_tab = 9'd209;  5'd4: sig_tab = 9'd225;  5'd5: sig_tab = 9'd237;
      5'd6: sig_tab = 9'd244;  5'd7: sig_tab = 9'd248;  5'd8: sig_tab = 9'd251;
      5'd9: sig_tab = 9'd253;  5'd10: sig_tab = 9'd254; 5'd11: sig_tab = 9'd255;
      5'd12: sig_tab = 9'd255;
      default: sig_tab = 9'd256;
    endcase
  endfunction

  // saturate a signed 40-bit value to the data width
  function automatic logic signed [DATA_BITS-1:0] sat_d(input logic signed [39:0] v);
    logic signed [39:0] mx;
    logic signed [39:0] mn;
    mx = 40'sd1 <<< (DATA_BITS - 1);
    mn = -mx;
    mx = mx - 40'sd1;
    if (v > mx) sat_d = mx[DATA_BITS-1:0];
    else if (v < mn) sat_d = mn[DATA_BITS-1:0];
    else sat_d = v[DATA_BITS-1:0];
  endfunction

  // sigmoid of a signed value, result 0..256
  function automatic logic signed [10:0] sigm(input logic signed [17:0] x);
    logic [17:0] u;
    logic [8:0]  y0;
    logic [8:0]  y1;
    logic [6:0]  fr;
    logic [15:0] pr;
    logic [9:0]  y;
    u = x[17] ? 18'(-x) : 18'(x);
    y0 = sig_tab(u[11:7]);
    y1 = sig_tab(5'(u[11:7] + 5'd1));
    fr = u[6:0];
    pr = 16'(9'(y1 - y0)) * 16'(fr);
    if (u >= 18'd2048) y = 10'd256;
    else y = 10'(y0) + 10'(pr[15:7]);
    sigm = x[17] ? 11'sd256 - 11'($signed({1'b0, y})) : 11'($signed({1'b0, y}));
  endfunction

  // sequencer to datapath status
  typedef struct packed {
    logic [2:0] nl;
    logic [1:0] acts;
    logic       norm;
  } lay_cfg_t;

endpackage
`default_nettype wire

### rtl/mlp_forward_inference.sv
// ----------------------------------------------------------------------------
// mlp_forward_inference: Q8.8 multilayer perceptron inference
// Loads parameters and samples, runs layers serially on one MAC, streams out.
// Loads and non-last samples are taken while the block is idle. The last sample
// starts a pass over the layers, one serial multiply-accumulate per cycle through
// the weight memory read port, then streams the results out; input is held off
// until the last result beat is taken. Reset is synchronous; mean/inv_dev reset
// state is tracked by per-entry valid bits, gamma/beta are registers.
// ----------------------------------------------------------------------------
`default_nettype none
module mlp_forward_inference (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // [2:0] operation, [4:3] layer_sel, [8:5] row_sel, [12:9] col_sel,
  // [28:13] data_value, zero pad to 32
  input  wire  [31:0] s_tdata,
  input  wire         s_tlast,   // sample_last
  output logic        m_tvalid,
  input  wire         m_tready,
  // [3:0] out_index, [19:4] out_value, zero pad to 24
  output logic [23:0] m_tdata,
  output logic        m_tlast,   // out_last
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_index,
  input  wire  [7:0]  cfg_data
);
  import mlp_pkg::*;

  typedef logic signed [DATA_BITS-1:0] d_t;

  // configuration
  logic [2:0] layer_count;
  logic [4:0] widths [4];
  logic [7:0] act_codes;
  logic [3:0] norm_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count <= 3'd2;
      for (int i = 0; i < 4; i++) widths[i] <= 5'd16;
      act_codes <= '0;
      norm_en <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LAYER_COUNT: layer_count <= cfg_data[2:0];
        REG_WIDTH0: widths[0] <= cfg_data[4:0];
        REG_WIDTH1: widths[1] <= cfg_data[4:0];
        REG_WIDTH2: widths[2] <= cfg_data[4:0];
        REG_WIDTH3: widths[3] <= cfg_data[4:0];
        REG_ACT_CODES: act_codes <= cfg_data;
        REG_NORM_EN: norm_en <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // clamped width, count is 1..16 held as is (0 reads as 1)
  function automatic logic [WIDX_BITS:0] wid(input logic [4:0] w);
    if (w == 5'd0) wid = (WIDX_BITS+1)'(1);
    else if (w > 5'(MAX_WIDTH < 16 ? MAX_WIDTH : 16))
      wid = (WIDX_BITS+1)'(MAX_WIDTH < 16 ? MAX_WIDTH : 16);
    else wid = (WIDX_BITS+1)'(w);
  endfunction

  localparam int LCAP = MAX_LAYERS < 4 ? MAX_LAYERS : 4;
  logic [2:0] nl;
  always_comb begin
    if (layer_count < 3'd2) nl = 3'd2;
    else if (layer_count > 3'(LCAP)) nl = 3'(LCAP);
    else nl = layer_count;
  end

  // input field split
  op_t                  op;
  logic [1:0]           lsel;
  logic [3:0]           rsel;
  logic [3:0]           csel;
  d_t                   dval;
  assign op   = op_t'(s_tdata[2:0]);
  assign lsel = s_tdata[4:3];
  assign rsel = s_tdata[8:5];
  assign csel = s_tdata[12:9];
  assign dval = s_tdata[28:13];

  state_t state, state_next;
  logic   acc_in;
  assign s_tready = (state == ST_IDLE);
  assign acc_in = s_tvalid && s_tready;
  logic lay_ok, row_ok, col_ok;
  assign lay_ok = 32'(lsel) < MAX_LAYERS;
  assign row_ok = 32'(rsel) < MAX_WIDTH;
  assign col_ok = 32'(csel) < MAX_WIDTH;
  logic load_ok;
  assign load_ok = acc_in && lay_ok && row_ok;

  // pass counters
  logic [2:0]           lay;     // current computed layer
  logic [WIDX_BITS:0]   j;       // neuron
  logic [WIDX_BITS:0]   k;       // source
  logic [WIDX_BITS:0]   wcur, wprev;
  assign wcur  = wid(widths[lay[1:0]]);
  assign wprev = wid(widths[2'(lay - 3'd1)]);
  logic [1:0] lb;
  assign lb = lay[1:0];

  // weight memory
  logic                  w_we;
  logic [WADDR_BITS-1:0] w_wa, w_ra;
  logic [15:0]           w_rd;
  assign w_we = load_ok && op == OP_WEIGHT && lsel != 2'd0 && col_ok;
  assign w_wa = WADDR_BITS'(((32'(lsel) - 1) * MAX_WIDTH + 32'(rsel)) * MAX_WIDTH + 32'(csel));
  assign w_ra = WADDR_BITS'(((32'(lay) - 1) * MAX_WIDTH + 32'(j)) * MAX_WIDTH + 32'(k));
  mlp_ram #(.WIDTH(16), .DEPTH(WMEM_DEPTH)) u_wmem (
    .clk(clk), .we(w_we), .waddr(w_wa), .wdata(dval), .raddr(w_ra), .rdata(w_rd));

  // bias memory
  logic                  b_we;
  logic [BADDR_BITS-1:0] b_wa, b_ra;
  logic [15:0]           b_rd;
  assign b_we = load_ok && op == OP_BIAS && lsel != 2'd0;
  assign b_wa = BADDR_BITS'((32'(lsel) - 1) * MAX_WIDTH + 32'(rsel));
  assign b_ra = BADDR_BITS'((32'(lay) - 1) * MAX_WIDTH + 32'(j));
  mlp_ram #(.WIDTH(16), .DEPTH(BMEM_DEPTH)) u_bmem (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(dval), .raddr(b_ra), .rdata(b_rd));

  // mean / inverse deviation memories with valid bits for the reset value
  logic [NADDR_BITS-1:0] n_wa, n_ra;
  logic [15:0]           mean_rd, inv_rd;
  logic                  m_we, i_we;
  logic [NMEM_DEPTH-1:0] mean_v, inv_v;
  logic                  mean_vr, inv_vr;
  assign n_wa = NADDR_BITS'(32'(lsel) * MAX_WIDTH + 32'(rsel));
  assign n_ra = NADDR_BITS'(32'(lay) * MAX_WIDTH + 32'(j));
  assign m_we = load_ok && op == OP_MEAN;
  assign i_we = load_ok && op == OP_INVDEV;
  mlp_ram #(.WIDTH(16), .DEPTH(NMEM_DEPTH)) u_mmem (
    .clk(clk), .we(m_we), .waddr(n_wa), .wdata(dval), .raddr(n_ra), .rdata(mean_rd));
  mlp_ram #(.WIDTH(16), .DEPTH(NMEM_DEPTH)) u_imem (
    .clk(clk), .we(i_we), .waddr(n_wa), .wdata(dval), .raddr(n_ra), .rdata(inv_rd));

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_v <= '0;
      inv_v <= '0;
    end else begin
      if (m_we) mean_v[n_wa] <= 1'b1;
      if (i_we) inv_v[n_wa] <= 1'b1;
    end
    mean_vr <= mean_v[n_ra];
    inv_vr <= inv_v[n_ra];
  end

  // per-layer gamma and beta
  d_t gamma [MAX_LAYERS];
  d_t beta  [MAX_LAYERS];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_LAYERS; i++) begin
        gamma[i] <= d_t'(256);
        beta[i] <= '0;
      end
    end else if (load_ok && op == OP_GAMMA) begin
      gamma[lsel] <= dval;
    end else if (load_ok && op == OP_BETA) begin
      beta[lsel] <= dval;
    end
  end

  // activation buffer: two banks
  logic                  a_we;
  logic [AADDR_BITS-1:0] a_wa, a_ra;
  logic [15:0]           a_wd, a_rd;
  logic                  smp_we;
  logic [AADDR_BITS-1:0] pass_wa;
  logic [15:0]           pass_wd;
  logic                  pass_we;
  assign smp_we = acc_in && op == OP_SAMPLE && row_ok;
  assign a_we = smp_we || pass_we;
  assign a_wa = smp_we ? AADDR_BITS'(rsel) : pass_wa;
  assign a_wd = smp_we ? dval : pass_wd;
  mlp_ram #(.WIDTH(16), .DEPTH(AMEM_DEPTH)) u_amem (
    .clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));

  // bank of layer l source is (l&1), destination ((l+1)&1); layer 0 -> bank 1
  always_comb begin
    case (state)
      ST_IN_RD: a_ra = AADDR_BITS'(j);
      ST_OUT_RD: a_ra = AADDR_BITS'(32'(nl[0]) * MAX_WIDTH + 32'(j));
      default: a_ra = AADDR_BITS'(32'(lay[0]) * MAX_WIDTH + 32'(k));
    endcase
  end

  // datapath registers
  logic signed [31:0] acc;
  logic               mac_v;     // product pending from the previous read
  d_t                 a_val;
  logic signed [31:0] pnorm;
  logic signed [31:0] prod;
  logic signed [32:0] acc_sum;
  logic signed [31:0] acc_sat;

  // MAC: operands read in one cycle, multiplied and added the next
  assign prod = $signed(w_rd) * $signed(a_rd);
  assign acc_sum = 33'(acc) + 33'(prod);
  always_comb begin
    if (acc_sum > 33'sh0_7FFF_FFFF) acc_sat = 32'sh7FFF_FFFF;
    else if (acc_sum < -33'sh0_8000_0000) acc_sat = 32'sh8000_0000;
    else acc_sat = acc_sum[31:0];
  end

  // post processing: scale, activation
  d_t        scaled;
  d_t        acted;
  logic [1:0] acode;
  assign scaled = sat_d(40'(acc >>> 8));
  assign acode  = act_codes[2*lb +: 2];
  always_comb begin
    case (acode)
      ACT_RELU: acted = scaled > 0 ? scaled : '0;
      ACT_SIG:  acted = sat_d(40'(sigm(18'(scaled))));
      ACT_TANH: acted = sat_d(40'(12'(sigm(18'(scaled) <<< 1)) * 12'sd2 - 12'sd256));
      default:  acted = scaled;
    endcase
  end

  // normalization in two registered steps; the input layer takes the
  // buffer read directly in its first step
  d_t mean_e, inv_e;
  assign mean_e = mean_vr ? d_t'(mean_rd) : '0;
  assign inv_e  = inv_vr ? d_t'(inv_rd) : d_t'(256);
  logic signed [16:0] diff;
  logic signed [33:0] p1;
  logic signed [31:0] p2;
  d_t                 norm_out;
  assign diff = 17'(state == ST_IN_NORM1 ? d_t'(a_rd) : a_val) - 17'(mean_e);
  assign p1 = 34'(diff) * 34'(inv_e);
  assign p2 = $signed(gamma[lb]) * $signed(pnorm[15:0]);
  assign norm_out = sat_d(40'(p2 >>> 8) - 40'(beta[lb]));

  logic do_norm;
  assign do_norm = norm_en[lb];

  // output register
  logic [3:0] o_idx;
  d_t         o_val;
  logic       o_last;
  assign m_tdata = {4'd0, o_val, o_idx};
  assign m_tlast = o_last;
  assign m_tvalid = (state == ST_OUT);

  assign pass_we = (state == ST_IN_WR) || (state == ST_WR);
  assign pass_wa = (state == ST_IN_WR) ? AADDR_BITS'(MAX_WIDTH + 32'(j))
                 : AADDR_BITS'(32'(!lay[0]) * MAX_WIDTH + 32'(j));
  assign pass_wd = a_val;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:
        if (acc_in && op == OP_SAMPLE && s_tlast) state_next = ST_IN_RD;
      ST_IN_RD: state_next = ST_IN_NORM1;
      ST_IN_NORM1: state_next = ST_IN_NORM2;
      ST_IN_NORM2: state_next = ST_IN_WR;
      ST_IN_WR: state_next = (j + 1'b1 == wcur) ? ST_BIAS : ST_IN_RD;
      ST_BIAS: state_next = ST_MAC;
      ST_MAC: state_next = (k + 1'b1 == wprev) ? ST_MAC_LAST : ST_MAC;
      ST_MAC_LAST: state_next = ST_POST;
      ST_POST: state_next = ST_NORM1;
      ST_NORM1: state_next = ST_NORM2;
      ST_NORM2: state_next = ST_WR;
      ST_WR:
        if (j + 1'b1 != wcur) state_next = ST_BIAS;
        else if (lay + 3'd1 == nl) state_next = ST_OUT_RD;
        else state_next = ST_BIAS;
      ST_OUT_RD: state_next = ST_OUT_WAIT;
      ST_OUT_WAIT: state_next = ST_OUT;
      ST_OUT:
        if (m_tready) state_next = o_last ? ST_IDLE : ST_OUT_RD;
      default: state_next = ST_IDLE;
    endcase
  end

  // counters and datapath updates
  always_ff @(posedge clk) begin
    if (rst) begin
      lay <= 3'd0;
      j <= '0;
      k <= '0;
      mac_v <= 1'b0;
      acc <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          lay <= 3'd0;
          j <= '0;
          k <= '0;
        end
        ST_IN_WR: begin
          if (j + 1'b1 == wcur) begin
            j <= '0;
            lay <= 3'd1;
          end else j <= j + 1'b1;
        end
        ST_BIAS: begin
          k <= '0;
          mac_v <= 1'b0;
        end
        ST_MAC: begin
          if (!mac_v) acc <= 32'(d_t'(b_rd)) <<< 8;
          else acc <= acc_sat;
          mac_v <= 1'b1;
          k <= k + 1'b1;
        end
        ST_MAC_LAST: begin
          acc <= mac_v ? acc_sat : 32'(d_t'(b_rd)) <<< 8;
        end
        ST_WR: begin
          if (j + 1'b1 == wcur) begin
            j <= '0;
            lay <= lay + 3'd1;
          end else j <= j + 1'b1;
        end
        ST_OUT: if (m_tready) j <= j + 1'b1;
        default: ;
      endcase
    end
  end

  // value pipeline (payload only)
  always_ff @(posedge clk) begin
    case (state)
      ST_IN_NORM1: a_val <= d_t'(a_rd);
      ST_POST: a_val <= acted;
      default: ;
    endcase
    if (state == ST_IN_NORM1 || state == ST_NORM1)
      pnorm <= 32'(sat_d(40'(p1 >>> 8)));
    if ((state == ST_NORM2 || state == ST_IN_NORM2) && do_norm)
      a_val <= norm_out;
    if (state == ST_OUT_WAIT) begin
      o_idx <= 4'(j);
      o_val <= d_t'(a_rd);
      o_last <= (j + 1'b1 == wid(widths[2'(nl - 3'd1)]));
    end
  end

  // the first MAC cycle must load the bias, never add
  assert property (@(posedge clk) disable iff (rst)
    state == ST_BIAS |=> !mac_v) else $error("bias not loaded first");
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken during output");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR) |-> (lay != 3'd0 && lay < nl)) else $error("layer out of range");
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> state == ST_IDLE) else $error("no return");
endmodule
`default_nettype wire

### rtl/mlp_ram.sv
// ----------------------------------------------------------------------------
// mlp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mlp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### verif/mlp_forward_inference_test.sv
// ----------------------------------------------------------------------------
// mlp_forward_inference_test: self-checking bench for the Q8.8 MLP block
// Loads the block of weights and biases that the shapes used here can reach,
// then streams parameter writes and sample vectors under several network
// shapes. A predictor in the bench works out each output vector when the
// closing sample beat is taken. Both stream sides idle at random, and the
// output side holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
`default_nettype none
module mlp_forward_inference_test;
  import mlp_pkg::*;

  localparam int HANG_LIMIT = 20000;
  localparam int SETTLE     = 60;

  typedef struct {
    op_t        op;
    logic [1:0] lay;
    logic [3:0] row;
    logic [3:0] col;
    logic [15:0] val;
    logic       last;
  } load_beat_t;

  typedef struct {
    logic [3:0]  idx;
    logic [15:0] val;
    logic        last;
  } neuron_out_t;

  logic        clk, rst;
  logic        s_tvalid, s_tlast, m_tready, cfg_we;
  logic [31:0] s_tdata;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;
  wire         s_tready, m_tvalid, m_tlast;
  wire  [23:0] m_tdata;

  mlp_forward_inference u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // network state as the block should hold it
  logic signed [15:0] wt_mem [3*256];
  logic signed [15:0] bias_mem [48];
  logic signed [15:0] mean_mem [64];
  logic signed [15:0] idev_mem [64];
  logic signed [15:0] gamma_r [4];
  logic signed [15:0] beta_r [4];
  longint             act_buf [32];
  int                 layer_cnt, acts, norms;
  int                 wid [4];
  bit                 smp_ok [16];   // sample slots holding defined values

  load_beat_t  load_q [$];
  neuron_out_t vec_q [$];
  load_beat_t  cur;
  bit          in_fire;
  int          errors, idle_run, cyc, rx_count, hold_cnt, item_cnt;
  bit          held;

  int sig_tbl [17] = '{128, 159, 187, 209, 225, 237, 244, 248, 251,
                       253, 254, 255, 255, 256, 256, 256, 256};

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic int layer_width(int l);
    int w;
    w = wid[l];
    if (w < 1) w = 1;
    if (w > 16) w = 16;
    return w;
  endfunction

  function automatic int used_layers();
    int n;
    n = layer_cnt;
    if (n < 2) n = 2;
    if (n > 4) n = 4;
    return n;
  endfunction

  function automatic longint sigmoid_q8(longint x);
    longint u, y, seg, fr;
    u = x < 0 ? -x : x;
    if (u >= 2048) y = 256;
    else begin
      seg = u >>> 7;
      fr  = u & 127;
      y = sig_tbl[seg] + (((sig_tbl[seg+1] - sig_tbl[seg]) * fr) >>> 7);
    end
    return x < 0 ? 256 - y : y;
  endfunction

  function automatic longint batch_norm(int l, int i, longint a);
    longint p;
    p = sat16(((a - mean_mem[l*16+i]) * idev_mem[l*16+i]) >>> 8);
    return sat16(((gamma_r[l] * p) >>> 8) - beta_r[l]);
  endfunction

  // apply one accepted beat; a closing sample runs the whole network
  task automatic net_step(load_beat_t b);
    int nl, l, j, k, w, wp, src, dst;
    longint acc, a;
    logic [1:0] code;
    case (b.op)
      OP_WEIGHT: if (b.lay != 0) wt_mem[((b.lay-1)*16 + b.row)*16 + b.col] = b.val;
      OP_BIAS:   if (b.lay != 0) bias_mem[(b.lay-1)*16 + b.row] = b.val;
      OP_MEAN:   mean_mem[b.lay*16 + b.row] = b.val;
      OP_INVDEV: idev_mem[b.lay*16 + b.row] = b.val;
      OP_GAMMA:  gamma_r[b.lay] = b.val;
      OP_BETA:   beta_r[b.lay] = b.val;
      OP_SAMPLE: act_buf[b.row] = longint'($signed(b.val));
      default: ;
    endcase
    if (b.op != OP_SAMPLE || !b.last) return;
    nl = used_layers();
    w = layer_width(0);
    for (j = 0; j < w; j++) begin
      a = act_buf[j];
      if (norms[0]) a = batch_norm(0, j, a);
      act_buf[16+j] = a;
    end
    for (l = 1; l < nl; l++) begin
      src = (l & 1) * 16;
      dst = ((l + 1) & 1) * 16;
      wp = layer_width(l-1);
      w = layer_width(l);
      code = 2'(acts >> (2*l));
      for (j = 0; j < w; j++) begin
        acc = longint'(bias_mem[(l-1)*16+j]) * 256;
        for (k = 0; k < wp; k++)
          acc = sat32(acc + longint'(wt_mem[((l-1)*16+j)*16+k]) * act_buf[src+k]);
        a = sat16(acc >>> 8);
        case (code)
          ACT_RELU: a = a > 0 ? a : 0;
          ACT_SIG:  a = sat16(sigmoid_q8(a));
          ACT_TANH: a = sat16(2 * sigmoid_q8(2 * a) - 256);
          default: ;
        endcase
        if (norms[l]) a = batch_norm(l, j, a);
        act_buf[dst+j] = a;
      end
    end
    w = layer_width(nl-1);
    for (j = 0; j < w; j++)
      vec_q = {vec_q, neuron_out_t'{4'(j), act_buf[(nl&1)*16+j][15:0], j + 1 == w}};
  endtask

  // accept side: prediction, output checks, watchdog
  always @(posedge clk) begin
    neuron_out_t e;
    in_fire <= s_tvalid && s_tready;
    if (!rst) begin
      cyc <= cyc + 1;
      if (s_tvalid && s_tready) net_step(cur);
      if (m_tvalid && m_tready) begin
        rx_count <= rx_count + 1;
        if (vec_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected output beat %h last %b", m_tdata, m_tlast);
        end else begin
          e = vec_q.pop_front();
          if (m_tdata[3:0] !== e.idx || m_tdata[19:4] !== e.val || m_tlast !== e.last) begin
            errors++;
            if (errors <= 10)
              $display("output mismatch: exp idx %0d val %h last %b, got idx %0d val %h last %b",
                       e.idx, e.val, e.last, m_tdata[3:0], m_tdata[19:4], m_tlast);
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_run <= 0;
      else if (idle_run >= HANG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else idle_run <= idle_run + 1;
    end
  end

  function automatic bit no_idle_window();
    return (cyc % 6000) < 1500;
  endfunction

  // input driver
  always @(negedge clk) begin
    if (rst) s_tvalid <= 1'b0;
    else if (!s_tvalid || in_fire) begin
      if (load_q.size() > 0 && (no_idle_window() || $urandom_range(99) >= 38)) begin
        cur = load_q.pop_front();
        s_tdata  <= {3'b0, cur.val, cur.col, cur.row, cur.lay, 3'(cur.op)};
        s_tlast  <= cur.last;
        s_tvalid <= 1'b1;
      end else s_tvalid <= 1'b0;
    end
  end

  // output side: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (!held && rx_count >= 8) begin
      held = 1;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else m_tready <= no_idle_window() || $urandom_range(99) >= 38;
  end

  function automatic logic [15:0] rand_q88();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2, 3: return 16'($urandom());
      default: return 16'($signed($urandom_range(1024)) - 512);
    endcase
  endfunction

  task automatic queue_beat(op_t op, int lay, int row, int col, logic [15:0] val, bit last);
    int j;
    if (op == OP_SAMPLE) begin
      smp_ok[row] = 1;
      if (last) begin
        for (j = 0; j < layer_width(0); j++) if (!smp_ok[j]) last = 0;
      end
      // the pass rewrites part of the sample bank
      if (last) begin
        for (j = 0; j < layer_width(1); j++) smp_ok[j] = 1;
        if (used_layers() == 4) for (j = 0; j < layer_width(3); j++) smp_ok[j] = 1;
      end
    end
    load_q = {load_q, load_beat_t'{op, 2'(lay), 4'(row), 4'(col), val, last}};
    item_cnt++;
  endtask

  task automatic queue_vector();
    int j, w;
    w = layer_width(0);
    for (j = 0; j < w; j++) queue_beat(OP_SAMPLE, 0, j, $urandom_range(15), rand_q88(), j == w-1);
  endtask

  task automatic drain();
    wait (load_q.size() == 0 && !s_tvalid);
    @(posedge clk);
    wait (vec_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [7:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LAYER_COUNT: layer_cnt = v[2:0];
      REG_WIDTH0: wid[0] = v[4:0];
      REG_WIDTH1: wid[1] = v[4:0];
      REG_WIDTH2: wid[2] = v[4:0];
      REG_WIDTH3: wid[3] = v[4:0];
      REG_ACT_CODES: acts = v;
      REG_NORM_EN: norms = v[3:0];
      default: ;
    endcase
  endtask

  task automatic set_shape(int nl, int w0, int w1, int w2, int w3, int a, int n);
    reg_write(REG_LAYER_COUNT, 8'(nl));
    reg_write(REG_WIDTH0, 8'(w0));
    reg_write(REG_WIDTH1, 8'(w1));
    reg_write(REG_WIDTH2, 8'(w2));
    reg_write(REG_WIDTH3, 8'(w3));
    reg_write(REG_ACT_CODES, 8'(a));
    reg_write(REG_NORM_EN, 8'(n));
  endtask

  // layer 1 may be wide (up to 16); the others stay within 4 neurons
  function automatic int rand_width(bit wide);
    case ($urandom_range(9))
      0: return 0;
      1: return wide ? 31 : 4;
      2: return wide ? 16 : 1;
      default: return $urandom_range(1, wide ? 6 : 4);
    endcase
  endfunction

  initial begin
    int l, r, c, g, phase;
    op_t op;
    rst = 1; s_tvalid = 0; s_tdata = 0; s_tlast = 0; m_tready = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    errors = 0; idle_run = 0; cyc = 0; rx_count = 0; hold_cnt = 0; held = 0;
    item_cnt = 0; in_fire = 0;
    layer_cnt = 2; wid = '{16, 16, 16, 16}; acts = 0; norms = 0;
    for (l = 0; l < 64; l++) begin mean_mem[l] = 0; idev_mem[l] = 256; end
    for (l = 0; l < 4; l++) begin gamma_r[l] = 256; beta_r[l] = 0; end
    for (l = 0; l < 32; l++) act_buf[l] = 0;
    for (l = 0; l < 16; l++) smp_ok[l] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst = 0;

    // weights and biases reachable by the shapes below:
    // layer 1 16x4, layer 2 4x16, layer 3 4x4
    for (l = 1; l < 4; l++)
      for (r = 0; r < (l == 1 ? 16 : 4); r++) begin
        queue_beat(OP_BIAS, l, r, 0, 16'($signed($urandom_range(512)) - 256), 0);
        for (c = 0; c < (l == 2 ? 16 : 4); c++)
          queue_beat(OP_WEIGHT, l, r, c, 16'($signed($urandom_range(256)) - 128), 0);
      end

    // directed: extremes, ignored writes, stray last marks, normalization loads
    queue_beat(OP_WEIGHT, 1, 15, 15, 16'h7fff, 0);
    queue_beat(OP_WEIGHT, 1, 0, 0, 16'h8000, 0);
    queue_beat(OP_WEIGHT, 0, 3, 3, 16'h1234, 1);
    queue_beat(OP_BIAS, 0, 2, 0, 16'h7fff, 0);
    queue_beat(OP_BIAS, 1, 15, 0, 16'h8000, 0);
    queue_beat(OP_NONE, 3, 15, 15, 16'hffff, 1);
    queue_beat(OP_MEAN, 0, 0, 0, 16'h0100, 0);
    queue_beat(OP_INVDEV, 0, 1, 0, 16'h7fff, 0);
    queue_beat(OP_INVDEV, 1, 15, 0, 16'h8000, 0);
    queue_beat(OP_GAMMA, 1, 0, 0, 16'h0200, 1);
    queue_beat(OP_BETA, 3, 0, 0, 16'h8000, 0);
    queue_beat(OP_GAMMA, 0, 0, 0, 16'h7fff, 0);
    queue_beat(OP_BETA, 0, 0, 0, 16'h0080, 0);
    drain();

    // directed shapes: deepest with tanh and all norms, wide clamped high,
    // clamped low, layer count clamped high
    set_shape(4, 4, 16, 4, 4, {ACT_TANH, ACT_TANH, ACT_TANH, ACT_NONE}, 15);
    queue_vector();
    drain();
    // two vectors so that the long hold-off backs up the input side
    set_shape(2, 4, 31, 0, 0, {ACT_NONE, ACT_NONE, ACT_RELU, ACT_NONE}, 3);
    queue_vector();
    queue_vector();
    drain();
    set_shape(0, 0, 0, 0, 0, {ACT_SIG, ACT_SIG, ACT_SIG, ACT_SIG}, 0);
    queue_beat(OP_SAMPLE, 0, 0, 0, 16'h7fff, 1);
    queue_beat(OP_SAMPLE, 0, 0, 0, 16'h8000, 1);
    drain();
    set_shape(7, 3, 1, 4, 3, {ACT_RELU, ACT_SIG, ACT_RELU, ACT_NONE}, 10);
    queue_vector();
    drain();

    // random phases
    phase = 0;
    while (item_cnt < 260) begin
      set_shape($urandom_range(7), rand_width(0), rand_width(1), rand_width(0), rand_width(0),
                $urandom_range(255), $urandom_range(15));
      for (g = 0; g < 6; g++) begin
        if ($urandom_range(9) < 7) queue_vector();
        else repeat ($urandom_range(1, 4)) begin
          op = op_t'($urandom_range(7));
          queue_beat(op, $urandom_range(3), $urandom_range(15), $urandom_range(15),
                     op == OP_INVDEV && $urandom_range(1) ? 16'($urandom_range(512))
                                                          : rand_q88(),
                     $urandom_range(1));
        end
      end
      drain();
      phase++;
    end

    drain();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire
